### rtl/cxz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxz_pkg
// Shared types and constants for the controlled-X / controlled-Z engine.
// ----------------------------------------------------------------------------
package cxz_pkg;

  localparam int CmdW   = 2;
  localparam int BasisW = 10;
  localparam int QubitW = 4;
  localparam int OutW   = 16;

  typedef enum logic [CmdW-1:0] {
    CmdWrite = 2'd0,
    CmdRead  = 2'd1,
    CmdCx    = 2'd2,
    CmdCz    = 2'd3
  } cmd_e;

  // read request issued by the gate sweep
  typedef struct packed {
    logic valid;   // a read is issued this cycle
    logic second;  // read of the partner entry (target bit set)
  } rd_req_t;

endpackage

### rtl/cxz_amp_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxz_amp_mem
// Amplitude store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cxz_amp_mem #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cxz_addr_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxz_addr_gen
// Gate sweep sequencer: enumerates the entries with the control bit set.
// CX issues each pair as target clear, then target set; CZ issues
// one entry with both bits set per cycle.
// ----------------------------------------------------------------------------
module cxz_addr_gen
  import cxz_pkg::*;
#(
  parameter int QUBITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QubitW-1:0] ctl_i,
  input  logic [QubitW-1:0] tgt_i,
  input  logic              cz_i,
  output rd_req_t           req_o,
  output logic [QUBITS-1:0] addr_o
);

  localparam int AW = QUBITS;
  localparam int CW = (QUBITS > 2) ? QUBITS - 2 : 1;
  localparam logic [CW-1:0] KLast = CW'((1 << (QUBITS - 2)) - 1);

  logic              busy_q, busy_d;
  logic              phase_q, phase_d;
  logic [CW-1:0]     k_q, k_d;
  logic [QubitW-1:0] lo_pos_q, hi_pos_q, tgt_q;
  logic              lo_bit_q, hi_bit_q, cz_q;

  logic [AW-1:0] idx_lo, idx_base, idx_pair;

  // open a zero at pos, shifting the upper bits up, and place b there
  function automatic logic [AW-1:0] ins_bit(logic [AW-1:0] x, logic [QubitW-1:0] pos,
                                            logic b);
    logic [AW-1:0] low_mask;
    low_mask = (AW'(1) << pos) - AW'(1);
    return ((x & ~low_mask) << 1) | (x & low_mask) | (AW'(b) << pos);
  endfunction

  assign idx_lo   = ins_bit(AW'(k_q), lo_pos_q, lo_bit_q);
  assign idx_base = ins_bit(idx_lo, hi_pos_q, hi_bit_q);
  assign idx_pair = idx_base | (AW'(1) << tgt_q);

  assign req_o.valid  = busy_q;
  assign req_o.second = phase_q;
  assign addr_o       = phase_q ? idx_pair : idx_base;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    k_d     = k_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      k_d     = '0;
    end else if (busy_q) begin
      if (!cz_q && !phase_q) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        if (k_q == KLast) begin
          busy_d = 1'b0;
        end else begin
          k_d = k_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      k_q     <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      k_q     <= k_d;
    end
  end

  // control bit is always 1; target bit is 1 only for CZ
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cz_q  <= cz_i;
      tgt_q <= tgt_i;
      if (ctl_i < tgt_i) begin
        lo_pos_q <= ctl_i;
        lo_bit_q <= 1'b1;
        hi_pos_q <= tgt_i;
        hi_bit_q <= cz_i;
      end else begin
        lo_pos_q <= tgt_i;
        lo_bit_q <= cz_i;
        hi_pos_q <= ctl_i;
        hi_bit_q <= 1'b1;
      end
    end
  end

endmodule

### rtl/controlled_x_z_state_vector_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// controlled_x_z_state_vector_engine
// State-vector store with amplitude write/read and controlled-X / controlled-Z
// gates applied by a read-modify-write sweep over one memory.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid_i / in_ready_o | command, basis_index, write_real/imag,
//          |                        | control_qubit, target_qubit
//  out     | out_valid_o/out_ready_i | read_real, read_imag, index_error
//
//  CX: two reads per pair on the single read port.
//  CZ: one entry per cycle.
//  One item in flight; the next item is taken while the result waits in the
//  output register. Store contents are undefined after reset until written.
// ----------------------------------------------------------------------------
module controlled_x_z_state_vector_engine
  import cxz_pkg::*;
#(
  parameter int QUBITS   = 10,
  parameter int AMP_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CmdW-1:0]          command_i,
  input  logic [BasisW-1:0]        basis_index_i,
  input  logic signed [OutW-1:0]   write_real_i,
  input  logic signed [OutW-1:0]   write_imag_i,
  input  logic [QubitW-1:0]        control_qubit_i,
  input  logic [QubitW-1:0]        target_qubit_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [OutW-1:0]   read_real_o,
  output logic signed [OutW-1:0]   read_imag_o,
  output logic                     index_error_o
);

  localparam int AW = QUBITS;
  localparam int DW = 2 * AMP_BITS;
  localparam int WW = 34;

  localparam logic signed [WW-1:0] AmpMaxW = (WW'(1) <<< (AMP_BITS - 1)) - WW'(1);
  localparam logic signed [WW-1:0] AmpMinW = -AmpMaxW - WW'(1);
  localparam logic signed [WW-1:0] OutMaxW = 34'sd32767;
  localparam logic signed [WW-1:0] OutMinW = -34'sd32768;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StWrite   = 3'd1;
  localparam logic [2:0] StRdIssue = 3'd2;
  localparam logic [2:0] StRdData  = 3'd3;
  localparam logic [2:0] StGate    = 3'd4;
  localparam logic [2:0] StResp    = 3'd5;

  function automatic logic signed [AMP_BITS-1:0] clamp_in(logic signed [OutW-1:0] v);
    logic signed [WW-1:0] w;
    w = WW'(v);
    if (w > AmpMaxW) return AMP_BITS'(AmpMaxW);
    if (w < AmpMinW) return AMP_BITS'(AmpMinW);
    return AMP_BITS'(w);
  endfunction

  function automatic logic signed [OutW-1:0] sat_out(logic signed [AMP_BITS-1:0] v);
    logic signed [WW-1:0] w;
    w = WW'(v);
    if (w > OutMaxW) return OutW'(OutMaxW);
    if (w < OutMinW) return OutW'(OutMinW);
    return OutW'(w);
  endfunction

  function automatic logic signed [AMP_BITS-1:0] neg_sat(logic signed [AMP_BITS-1:0] v);
    if (v == AMP_BITS'(AmpMinW)) return AMP_BITS'(AmpMaxW);
    return -v;
  endfunction

  logic [2:0] state_q, state_d;
  cmd_e       cmd_q;
  logic [AW-1:0] addr_q;
  logic signed [AMP_BITS-1:0] wre_q, wim_q;
  logic signed [OutW-1:0] res_re_q, res_im_q;
  logic       res_err_q;
  logic       out_valid_q;
  logic signed [OutW-1:0] out_re_q, out_im_q;
  logic       out_err_q;

  logic       in_acc, is_gate, gate_err, gen_start, gate_done, out_load;

  rd_req_t       gen_req;
  logic [AW-1:0] gen_addr;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic signed [AMP_BITS-1:0] rd_re, rd_im;

  logic          s1_valid_q, s1_second_q;
  logic [AW-1:0] s1_addr_q, pair_addr_q, pend_addr_q;
  logic [DW-1:0] hold_q, pend_data_q;
  logic          pend_valid_q, pend_valid_d;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_gate    = (command_i == CmdCx) || (command_i == CmdCz);
  assign gate_err   = (control_qubit_i == target_qubit_i)
                   || ({1'b0, control_qubit_i} >= 5'(QUBITS))
                   || ({1'b0, target_qubit_i} >= 5'(QUBITS));
  assign gen_start  = in_acc && is_gate && !gate_err;
  assign gate_done  = !gen_req.valid && !s1_valid_q && !pend_valid_q;
  assign out_load   = (state_q == StResp) && (!out_valid_q || out_ready_i);

  cxz_addr_gen #(
    .QUBITS(QUBITS)
  ) u_addr_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(gen_start),
    .ctl_i  (control_qubit_i),
    .tgt_i  (target_qubit_i),
    .cz_i   (command_i == CmdCz),
    .req_o  (gen_req),
    .addr_o (gen_addr)
  );

  cxz_amp_mem #(
    .AW(AW),
    .DW(DW)
  ) u_amp_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign rd_re = mem_rdata[DW-1:AMP_BITS];
  assign rd_im = mem_rdata[AMP_BITS-1:0];

  assign mem_re    = gen_req.valid || (state_q == StRdIssue);
  assign mem_raddr = gen_req.valid ? gen_addr : addr_q;

  // CX pair: entry i is written with j's data when j arrives; j is written
  // with i's data in the next cycle from the pending slot.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr_q;
    mem_wdata = pend_data_q;
    priority if (state_q == StWrite) begin
      mem_we    = 1'b1;
      mem_waddr = addr_q;
      mem_wdata = {wre_q, wim_q};
    end else if (pend_valid_q) begin
      mem_we    = 1'b1;
    end else if (s1_valid_q && (cmd_q == CmdCz)) begin
      mem_we    = 1'b1;
      mem_waddr = s1_addr_q;
      mem_wdata = {neg_sat(rd_re), neg_sat(rd_im)};
    end else if (s1_valid_q && s1_second_q) begin
      mem_we    = 1'b1;
      mem_waddr = pair_addr_q;
      mem_wdata = mem_rdata;
    end else begin
      mem_we    = 1'b0;
    end
  end

  assign pend_valid_d = s1_valid_q && (cmd_q == CmdCx) && s1_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      s1_valid_q   <= gen_req.valid;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_second_q <= gen_req.second;
    s1_addr_q   <= gen_addr;
    if (s1_valid_q && !s1_second_q) begin
      hold_q      <= mem_rdata;
      pair_addr_q <= s1_addr_q;
    end
    if (pend_valid_d) begin
      pend_addr_q <= s1_addr_q;
      pend_data_q <= hold_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (cmd_e'(command_i))
            CmdWrite:    state_d = StWrite;
            CmdRead:     state_d = StRdIssue;
            CmdCx, CmdCz: state_d = gate_err ? StResp : StGate;
            default:     state_d = StResp;
          endcase
        end
      end
      StWrite:   state_d = StResp;
      StRdIssue: state_d = StRdData;
      StRdData:  state_d = StResp;
      StGate:    if (gate_done) state_d = StResp;
      StResp:    if (out_load) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= CmdWrite;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cmd_q <= cmd_e'(command_i);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q    <= AW'(basis_index_i);
      wre_q     <= clamp_in(write_real_i);
      wim_q     <= clamp_in(write_imag_i);
      res_re_q  <= '0;
      res_im_q  <= '0;
      res_err_q <= is_gate && gate_err;
    end else if (state_q == StRdData) begin
      res_re_q  <= sat_out(rd_re);
      res_im_q  <= sat_out(rd_im);
    end
    if (out_load) begin
      out_re_q  <= res_re_q;
      out_im_q  <= res_im_q;
      out_err_q <= res_err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_real_o   = out_re_q;
  assign read_imag_o   = out_im_q;
  assign index_error_o = out_err_q;

  // pending partner write always drains in the next cycle
  a_pend_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |=> !pend_valid_q)
    else $error("pending CX write not drained");

  // sweep reads only while a gate is in progress
  a_sweep_in_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_req.valid |-> (state_q == StGate))
    else $error("sweep read outside gate");

  // new item only when the read-modify-write pipe is empty
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!s1_valid_q && !pend_valid_q && !gen_req.valid))
    else $error("item accepted with sweep in flight");

  // error flag only for gate commands
  a_err_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StResp && res_err_q) |-> (cmd_q == CmdCx || cmd_q == CmdCz))
    else $error("index error on non-gate command");

  // a host write never shares the write port with sweep traffic
  a_write_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |-> (!pend_valid_q && !s1_valid_q))
    else $error("write port conflict");

endmodule

### tb/controlled_x_z_state_vector_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// controlled_x_z_state_vector_engine_test
// Fills the amplitude store, runs directed corner cases (full-scale values,
// CZ on the most negative value, CX/CZ at the qubit extremes, bad qubit
// indices), then random write/read/CX/CZ traffic. A state-vector model in the
// scoreboard predicts every result item; both channels stall at random.
// ----------------------------------------------------------------------------
module controlled_x_z_state_vector_engine_test;
  import cxz_pkg::*;

  localparam int QUBITS     = 10;
  localparam int DIM        = 1 << QUBITS;
  localparam int RAND_ITEMS = 123;
  localparam int IDLE_PCT   = 6;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  typedef struct {
    logic signed [OutW-1:0] re;
    logic signed [OutW-1:0] im;
    logic                   err;
  } readout_t;

  // Amplitude store model plus queue of expected readouts.
  class state_vector_sb;
    logic signed [OutW-1:0] amp_re [DIM];
    logic signed [OutW-1:0] amp_im [DIM];
    readout_t readouts_q[$];
    int errors, checked;
    int n_write, n_read, n_cx, n_cz, n_bad;

    function int pending();
      return readouts_q.size();
    endfunction

    function logic signed [OutW-1:0] neg_sat(logic signed [OutW-1:0] v);
      if (v == 16'sh8000) return 16'sh7fff;
      return -v;
    endfunction

    function void note_command(cmd_e cmd, logic [BasisW-1:0] idx,
                               logic signed [OutW-1:0] wr, logic signed [OutW-1:0] wi,
                               logic [QubitW-1:0] ctl, logic [QubitW-1:0] tgt);
      readout_t r;
      int i, j;
      logic signed [OutW-1:0] t_re, t_im;
      r.re  = '0;
      r.im  = '0;
      r.err = 1'b0;
      case (cmd)
        CmdWrite: begin
          n_write++;
          amp_re[idx % DIM] = wr;
          amp_im[idx % DIM] = wi;
        end
        CmdRead: begin
          n_read++;
          r.re = amp_re[idx % DIM];
          r.im = amp_im[idx % DIM];
        end
        default: begin
          if (cmd == CmdCx) n_cx++;
          else n_cz++;
          if (ctl == tgt || ctl >= QUBITS || tgt >= QUBITS) begin
            n_bad++;
            r.err = 1'b1;
          end else begin
            for (i = 0; i < DIM; i++) begin
              if (((i >> ctl) & 1) == 0) continue;
              if (cmd == CmdCx && ((i >> tgt) & 1) == 0) begin
                j = i | (1 << tgt);
                t_re = amp_re[i];
                t_im = amp_im[i];
                amp_re[i] = amp_re[j];
                amp_im[i] = amp_im[j];
                amp_re[j] = t_re;
                amp_im[j] = t_im;
              end else if (cmd == CmdCz && ((i >> tgt) & 1) == 1) begin
                amp_re[i] = neg_sat(amp_re[i]);
                amp_im[i] = neg_sat(amp_im[i]);
              end
            end
          end
        end
      endcase
      readouts_q.push_back(r);
    endfunction

    function void check_readout(logic signed [OutW-1:0] rr, logic signed [OutW-1:0] ri,
                                logic err);
      readout_t want;
      if (readouts_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item: real %0d imag %0d error %0b",
                 $time, rr, ri, err);
        return;
      end
      want = readouts_q.pop_front();
      checked++;
      if (rr !== want.re) begin
        errors++;
        $display("%0t: read_real expected %0d, got %0d", $time, want.re, rr);
      end
      if (ri !== want.im) begin
        errors++;
        $display("%0t: read_imag expected %0d, got %0d", $time, want.im, ri);
      end
      if (err !== want.err) begin
        errors++;
        $display("%0t: index_error expected %0b, got %0b", $time, want.err, err);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_ni;
  logic                   in_valid;
  logic                   in_ready;
  logic [CmdW-1:0]        command;
  logic [BasisW-1:0]      basis_index;
  logic signed [OutW-1:0] write_real;
  logic signed [OutW-1:0] write_imag;
  logic [QubitW-1:0]      control_qubit;
  logic [QubitW-1:0]      target_qubit;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [OutW-1:0] read_real;
  logic signed [OutW-1:0] read_imag;
  logic                   index_error;

  state_vector_sb sb;
  logic           quiet;
  int unsigned    cycle_count = 0;

  controlled_x_z_state_vector_engine #(
    .QUBITS  (QUBITS),
    .AMP_BITS(16)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .basis_index_i  (basis_index),
    .write_real_i   (write_real),
    .write_imag_i   (write_imag),
    .control_qubit_i(control_qubit),
    .target_qubit_i (target_qubit),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .read_real_o    (read_real),
    .read_imag_o    (read_imag),
    .index_error_o  (index_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: check with pre-edge values, then pick next ready.
  always @(posedge clk) begin
    if (rst_ni && out_valid && out_ready)
      sb.check_readout(read_real, read_imag, index_error);
    out_ready <= !(!quiet && $urandom_range(99) < IDLE_PCT);
  end

  function automatic logic signed [OutW-1:0] rand_amp();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return OutW'($urandom());
    endcase
  endfunction

  task automatic send_item(cmd_e cmd, logic [BasisW-1:0] idx,
                           logic signed [OutW-1:0] wr, logic signed [OutW-1:0] wi,
                           logic [QubitW-1:0] ctl, logic [QubitW-1:0] tgt);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    basis_index   <= idx;
    write_real    <= wr;
    write_imag    <= wi;
    control_qubit <= ctl;
    target_qubit  <= tgt;
    do @(posedge clk); while (!in_ready);
    sb.note_command(cmd, idx, wr, wi, ctl, tgt);
  endtask

  // hold the input side until every pending result item has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int pick;
    cmd_e cmd;
    logic [QubitW-1:0] ctl, tgt;
    pick = $urandom_range(99);
    cmd  = cmd_e'(pick < 30 ? CmdWrite : pick < 62 ? CmdRead : pick < 81 ? CmdCx : CmdCz);
    ctl  = QubitW'($urandom_range(15));
    tgt  = QubitW'($urandom_range(15));
    if (cmd == CmdCx || cmd == CmdCz) begin
      if ($urandom_range(99) >= 8) begin
        ctl = QubitW'($urandom_range(QUBITS - 1));
        tgt = QubitW'($urandom_range(QUBITS - 2));
        if (tgt >= ctl) tgt = tgt + QubitW'(1);
      end else begin
        case ($urandom_range(2))
          0:       tgt = ctl;
          1:       ctl = QubitW'($urandom_range(15, QUBITS));
          default: tgt = QubitW'($urandom_range(15, QUBITS));
        endcase
      end
    end
    send_item(cmd, BasisW'($urandom()), rand_amp(), rand_amp(), ctl, tgt);
  endtask

  initial begin
    int k;
    sb            = new();
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    out_ready     = 1'b0;
    command       = CmdWrite;
    basis_index   = '0;
    write_real    = '0;
    write_imag    = '0;
    control_qubit = '0;
    target_qubit  = '0;
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // every entry written first, so no gate or read ever touches an undefined one
    for (k = 0; k < DIM; k++)
      send_item(CmdWrite, BasisW'(k), rand_amp(), rand_amp(),
                QubitW'($urandom()), QubitW'($urandom()));
    drain();

    // directed corners
    send_item(CmdWrite, 10'd0,    16'sh7fff, 16'sh8000, 4'd15, 4'd15);
    send_item(CmdWrite, 10'd1023, 16'sh8000, 16'sh7fff, 4'd0,  4'd0);
    send_item(CmdWrite, 10'd1,    -16'sd1,   16'sd1,    4'd3,  4'd7);
    send_item(CmdRead,  10'd0,    16'sh7fff, 16'sh7fff, 4'd0,  4'd0);
    send_item(CmdRead,  10'd1023, 16'sh0000, 16'sh0000, 4'd9,  4'd9);
    // CZ hits 1023, including the most negative value
    send_item(CmdCz,    10'd0,    16'sh0000, 16'sh0000, 4'd0,  4'd9);
    send_item(CmdRead,  10'd1023, 16'sh0000, 16'sh0000, 4'd0,  4'd0);
    send_item(CmdCz,    10'd1023, 16'sh0000, 16'sh0000, 4'd9,  4'd0);
    send_item(CmdRead,  10'd1023, 16'sh0000, 16'sh0000, 4'd0,  4'd0);
    send_item(CmdCx,    10'd0,    16'sh0000, 16'sh0000, 4'd0,  4'd1);
    send_item(CmdRead,  10'd1,    16'sh0000, 16'sh0000, 4'd0,  4'd0);
    send_item(CmdRead,  10'd3,    16'sh0000, 16'sh0000, 4'd0,  4'd0);
    send_item(CmdCx,    10'd1023, 16'sh7fff, 16'sh8000, 4'd9,  4'd0);
    send_item(CmdRead,  10'd512,  16'sh0000, 16'sh0000, 4'd0,  4'd0);
    send_item(CmdRead,  10'd513,  16'sh0000, 16'sh0000, 4'd0,  4'd0);
    // bad qubit indices: store must stay as is
    send_item(CmdCx,    10'd0,    16'sh0000, 16'sh0000, 4'd5,  4'd5);
    send_item(CmdCz,    10'd0,    16'sh0000, 16'sh0000, 4'd0,  4'd0);
    send_item(CmdCx,    10'd0,    16'sh0000, 16'sh0000, 4'd10, 4'd0);
    send_item(CmdCz,    10'd0,    16'sh0000, 16'sh0000, 4'd0,  4'd15);
    send_item(CmdCx,    10'd0,    16'sh0000, 16'sh0000, 4'd15, 4'd15);
    send_item(CmdCz,    10'd0,    16'sh0000, 16'sh0000, 4'd12, 4'd3);
    send_item(CmdRead,  10'd0,    16'sh0000, 16'sh0000, 4'd0,  4'd0);
    send_item(CmdRead,  10'd1023, 16'sh0000, 16'sh0000, 4'd0,  4'd0);
    drain();

    for (k = 0; k < RAND_ITEMS; k++) begin
      quiet = (k >= 40 && k < 90);
      if (k == 100) drain();
      send_random_item();
    end
    quiet = 1'b0;
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d writes, %0d reads, %0d CX, %0d CZ (%0d with bad qubit indices)",
             sb.n_write, sb.n_read, sb.n_cx, sb.n_cz, sb.n_bad);
    $display("%0d result items checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
rtl/cxz_pkg.sv
rtl/cxz_amp_mem.sv
rtl/cxz_addr_gen.sv
rtl/controlled_x_z_state_vector_engine.sv
tb/controlled_x_z_state_vector_engine_test.sv
